// ===== src/bfds_pkg.sv =====
// Shared types and constants for the box filter downscaler.
// No dependencies; imported by every module of the block.
package bfds_pkg;

    localparam int NUM_CH     = 4;
    localparam int CH_W       = 8;
    localparam int SUM_W      = 32;
    localparam int QUOT_STEPS = 8;
    localparam int SRC_CFG_W  = 13;
    localparam int DST_CFG_W  = 11;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_DIV
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== src/bfds_colmem.sv =====
// Column sum memory: one row of four 32-bit channel sums per destination column.
// One write port, one read port with registered data. Uses bfds_pkg.
module bfds_colmem #(
    parameter int AW = 10
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [AW-1:0]                                 i_waddr,
    input  logic [bfds_pkg::NUM_CH-1:0][bfds_pkg::SUM_W-1:0] i_wdata,
    input  logic                                          i_re,
    input  logic [AW-1:0]                                 i_raddr,
    output logic [bfds_pkg::NUM_CH-1:0][bfds_pkg::SUM_W-1:0] o_rdata
);
    import bfds_pkg::*;

    logic [NUM_CH*SUM_W-1:0] r_mem [2**AW];
    logic [NUM_CH*SUM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bfds_div.sv =====
// Four-lane restoring divider: box sum over pixel count, one quotient bit per cycle.
// The quotient never exceeds 8 bits, so eight steps finish it. Uses bfds_pkg.
module bfds_div #(
    parameter int CNTW = 26
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_start,
    input  logic [bfds_pkg::NUM_CH-1:0][bfds_pkg::SUM_W-1:0] i_sum,
    input  logic [CNTW-1:0]                                  i_cnt,
    output logic [bfds_pkg::NUM_CH-1:0][bfds_pkg::CH_W-1:0]  o_quot,
    output bfds_pkg::t_div_stat                              o_stat
);
    import bfds_pkg::*;

    localparam int WW = (CNTW + QUOT_STEPS - 1 > SUM_W) ? CNTW + QUOT_STEPS - 1 : SUM_W;
    localparam int KW = $clog2(QUOT_STEPS);

    logic [NUM_CH-1:0][SUM_W-1:0] r_rem;
    logic [NUM_CH-1:0][CH_W-1:0]  r_quot;
    logic [WW-1:0]                r_dv;
    logic [KW-1:0]                r_k;
    logic                         r_busy;
    logic                         r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_k    <= '0;
        end else if (r_busy) begin
            r_k <= r_k + KW'(1);
            if (r_k == KW'(QUOT_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_sum;
            r_dv  <= WW'(i_cnt) << (QUOT_STEPS - 1);
        end else if (r_busy) begin
            for (int l = 0; l < NUM_CH; l++) begin
                if (WW'(r_rem[l]) >= r_dv) begin
                    r_rem[l]  <= SUM_W'(WW'(r_rem[l]) - r_dv);
                    r_quot[l] <= {r_quot[l][CH_W-2:0], 1'b1};
                end else begin
                    r_quot[l] <= {r_quot[l][CH_W-2:0], 1'b0};
                end
            end
            r_dv <= r_dv >> 1;
        end
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== src/box_filter_image_downscaler.sv =====
// Box filter (area average) downscaler for RGBA8 pixels streamed in raster order.
// A source pixel that does not close a column span leaves the block ready for the next
// pixel. One that closes a span holds off further pixels while the column sum memory,
// whose read data is registered, goes through its read-modify-write in state S_RMW.
// One that also completes a destination pixel holds them off further, through the
// bit-serial divider and the load of the output register, and longer while the
// previous result still waits in the output register. After reset and after each
// register write the block reloads its position counters before it takes pixels.
// Depends on bfds_pkg, bfds_colmem and bfds_div.
module box_filter_image_downscaler #(
    parameter int MAX_SRC_WIDTH  = 4096,
    parameter int MAX_SRC_HEIGHT = 4096,
    parameter int MAX_DST_WIDTH  = 1024,
    parameter int MAX_DST_HEIGHT = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bfds_pkg::PADDR_W-1:0]   paddr,
    input  logic [bfds_pkg::PDATA_W-1:0]   pwdata,
    output logic [bfds_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_red,
    input  logic [7:0]                     i_green,
    input  logic [7:0]                     i_blue,
    input  logic [7:0]                     i_alpha,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [7:0]                     o_out_red,
    output logic [7:0]                     o_out_green,
    output logic [7:0]                     o_out_blue,
    output logic [7:0]                     o_out_alpha,
    output logic [9:0]                     o_dest_x,
    output logic [9:0]                     o_dest_y,
    output logic                           o_last_pixel
);
    import bfds_pkg::*;

    localparam int SWW  = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SHW  = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int DWW  = $clog2(MAX_DST_WIDTH + 1);
    localparam int DHW  = $clog2(MAX_DST_HEIGHT + 1);
    localparam int AW   = $clog2(MAX_DST_WIDTH);
    localparam int RW   = $clog2(MAX_DST_HEIGHT);
    localparam int KW   = SWW + DWW + 1;
    localparam int KRW  = SHW + DHW + 1;
    localparam int CNTW = SWW + SHW;
    localparam int SPW  = SWW + CH_W;

    // configuration
    logic [SRC_CFG_W-1:0] r_src_width, r_src_height;
    logic [DST_CFG_W-1:0] r_dst_width, r_dst_height;
    logic                 r_restart;
    logic                 cfg_wr;
    logic [SWW-1:0]       eff_sw;
    logic [SHW-1:0]       eff_sh;
    logic [DWW-1:0]       eff_dw, dw_cl;
    logic [DHW-1:0]       eff_dh, dh_cl;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SRC_CFG_W'(1);
            r_src_height <= SRC_CFG_W'(1);
            r_dst_width  <= DST_CFG_W'(1);
            r_dst_height <= DST_CFG_W'(1);
            r_restart    <= 1'b1;
        end else begin
            r_restart <= cfg_wr;
            if (cfg_wr) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_SRC_WIDTH:  r_src_width  <= pwdata[SRC_CFG_W-1:0];
                    REG_SRC_HEIGHT: r_src_height <= pwdata[SRC_CFG_W-1:0];
                    REG_DST_WIDTH:  r_dst_width  <= pwdata[DST_CFG_W-1:0];
                    REG_DST_HEIGHT: r_dst_height <= pwdata[DST_CFG_W-1:0];
                    default:        r_src_width  <= r_src_width;
                endcase
            end
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_SRC_WIDTH:  prdata = PDATA_W'(r_src_width);
            REG_SRC_HEIGHT: prdata = PDATA_W'(r_src_height);
            REG_DST_WIDTH:  prdata = PDATA_W'(r_dst_width);
            REG_DST_HEIGHT: prdata = PDATA_W'(r_dst_height);
            default:        prdata = '0;
        endcase
    end

    // effective sizes: zero acts as one, saturate at the maxima, clamp dst to src
    always_comb begin
        if (r_src_width == '0)                          eff_sw = SWW'(1);
        else if (32'(r_src_width) > 32'(MAX_SRC_WIDTH)) eff_sw = SWW'(MAX_SRC_WIDTH);
        else                                            eff_sw = SWW'(r_src_width);
        if (r_src_height == '0)                           eff_sh = SHW'(1);
        else if (32'(r_src_height) > 32'(MAX_SRC_HEIGHT)) eff_sh = SHW'(MAX_SRC_HEIGHT);
        else                                              eff_sh = SHW'(r_src_height);
        if (r_dst_width == '0)                          dw_cl = DWW'(1);
        else if (32'(r_dst_width) > 32'(MAX_DST_WIDTH)) dw_cl = DWW'(MAX_DST_WIDTH);
        else                                            dw_cl = DWW'(r_dst_width);
        if (r_dst_height == '0)                           dh_cl = DHW'(1);
        else if (32'(r_dst_height) > 32'(MAX_DST_HEIGHT)) dh_cl = DHW'(MAX_DST_HEIGHT);
        else                                              dh_cl = DHW'(r_dst_height);
        eff_dw = (32'(dw_cl) > 32'(eff_sw)) ? DWW'(eff_sw) : dw_cl;
        eff_dh = (32'(dh_cl) > 32'(eff_sh)) ? DHW'(eff_sh) : dh_cl;
    end

    // stream position. A column closes when (x+1)*sw < (s+2)*dw, a band likewise.
    t_state                       r_state, n_state;
    logic [SWW-1:0]               r_src_col, r_span_cols;
    logic [SHW-1:0]               r_band_rows;
    logic [AW-1:0]                r_dcol;
    logic [RW-1:0]                r_drow;
    logic [KW-1:0]                r_kc, r_mc;
    logic [KRW-1:0]               r_kr, r_mr;
    logic [NUM_CH-1:0][SPW-1:0]   r_span, span_nx;
    logic [NUM_CH-1:0][SPW-1:0]   r_acc;
    logic                         r_first, r_emit, r_olast_p;
    logic [AW-1:0]                r_ox;
    logic [RW-1:0]                r_oy;
    logic [CNTW-1:0]              r_cnt;
    logic [NUM_CH-1:0][CH_W-1:0]  pix;
    logic                         in_acc, col_close, row_close, row_end;
    logic                         dcol_last, drow_last;
    logic [SWW-1:0]               src_col_nx;

    assign pix        = {i_alpha, i_blue, i_green, i_red};
    assign o_ready    = (r_state == S_IDLE) && !r_restart;
    assign in_acc     = i_valid && o_ready;
    assign col_close  = r_kc < r_mc;
    assign row_close  = r_kr < r_mr;
    assign src_col_nx = r_src_col + SWW'(1);
    assign row_end    = src_col_nx >= eff_sw;
    assign dcol_last  = (DWW'(r_dcol) + DWW'(1)) >= eff_dw;
    assign drow_last  = (DHW'(r_drow) + DHW'(1)) >= eff_dh;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            span_nx[c] = r_span[c] + SPW'(pix[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col   <= '0;
            r_span_cols <= '0;
            r_band_rows <= '0;
            r_dcol      <= '0;
            r_drow      <= '0;
            r_kc        <= KW'(1);
            r_mc        <= KW'(2);
            r_kr        <= KRW'(1);
            r_mr        <= KRW'(2);
            r_span      <= '0;
        end else if (r_restart) begin
            r_src_col   <= '0;
            r_span_cols <= '0;
            r_band_rows <= '0;
            r_dcol      <= '0;
            r_drow      <= '0;
            r_kc        <= KW'(eff_sw);
            r_mc        <= KW'({eff_dw, 1'b0});
            r_kr        <= KRW'(eff_sh);
            r_mr        <= KRW'({eff_dh, 1'b0});
            r_span      <= '0;
        end else if (in_acc) begin
            if (col_close) begin
                r_span      <= '0;
                r_span_cols <= '0;
                if (dcol_last) begin
                    r_dcol <= '0;
                    r_kc   <= KW'(eff_sw);
                end else begin
                    r_dcol <= r_dcol + AW'(1);
                    r_kc   <= r_kc + KW'(eff_sw);
                end
            end else begin
                r_span      <= span_nx;
                r_span_cols <= r_span_cols + SWW'(1);
            end
            if (row_end) begin
                r_src_col <= '0;
                r_mc      <= KW'({eff_dw, 1'b0});
                if (row_close) begin
                    r_band_rows <= '0;
                    if (drow_last) begin
                        // image done: start the next one
                        r_drow <= '0;
                        r_kr   <= KRW'(eff_sh);
                        r_mr   <= KRW'({eff_dh, 1'b0});
                    end else begin
                        r_drow <= r_drow + RW'(1);
                        r_kr   <= r_kr + KRW'(eff_sh);
                        r_mr   <= r_mr + KRW'(eff_dh);
                    end
                end else begin
                    r_band_rows <= r_band_rows + SHW'(1);
                    r_mr        <= r_mr + KRW'(eff_dh);
                end
            end else begin
                r_src_col <= src_col_nx;
                r_mc      <= r_mc + KW'(eff_dw);
            end
        end
    end

    // hold what the write-back and the division need
    always_ff @(posedge i_clk) begin
        if (in_acc && col_close) begin
            r_acc     <= span_nx;
            r_first   <= (r_band_rows == '0);
            r_emit    <= row_close;
            r_ox      <= r_dcol;
            r_oy      <= r_drow;
            r_olast_p <= dcol_last && drow_last;
            r_cnt     <= CNTW'(r_span_cols + SWW'(1)) * CNTW'(r_band_rows + SHW'(1));
        end
    end

    // column sum read-modify-write
    logic [NUM_CH-1:0][SUM_W-1:0] mem_rdata, sum_new;
    logic                         mem_we;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            sum_new[c] = (r_first ? '0 : mem_rdata[c]) + SUM_W'(r_acc[c]);
        end
    end

    assign mem_we = (r_state == S_RMW);

    bfds_colmem #(
        .AW(AW)
    ) u_colmem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_ox),
        .i_wdata(sum_new),
        .i_re   (in_acc && col_close),
        .i_raddr(r_dcol),
        .o_rdata(mem_rdata)
    );

    // divider
    logic [NUM_CH-1:0][CH_W-1:0] quot;
    t_div_stat                   div_stat;
    logic                        div_start;
    logic                        out_free;
    logic                        out_load;

    assign div_start = (r_state == S_RMW) && r_emit;

    bfds_div #(
        .CNTW(CNTW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_sum  (sum_new),
        .i_cnt  (r_cnt),
        .o_quot (quot),
        .o_stat (div_stat)
    );

    assign out_free = !o_valid || i_ready;

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && col_close) n_state = S_RMW;
            end
            S_RMW: begin
                n_state = r_emit ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (div_stat.done && out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output register
    logic                        r_o_valid;
    logic [NUM_CH-1:0][CH_W-1:0] r_o_pix;
    logic [9:0]                  r_o_x, r_o_y;
    logic                        r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_pix  <= quot;
            r_o_x    <= 10'(r_ox);
            r_o_y    <= 10'(r_oy);
            r_o_last <= r_olast_p;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_red    = r_o_pix[0];
    assign o_out_green  = r_o_pix[1];
    assign o_out_blue   = r_o_pix[2];
    assign o_out_alpha  = r_o_pix[3];
    assign o_dest_x     = r_o_x;
    assign o_dest_y     = r_o_y;
    assign o_last_pixel = r_o_last;

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_state == S_IDLE))
        else $error("pixel beat taken outside idle");

    a_rmw_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |-> $past(in_acc && col_close))
        else $error("write-back without a closing pixel");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == S_DIV) && div_stat.busy)
        else $error("divider not running after start");

    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (div_stat.done && !div_stat.busy))
        else $error("output loaded before quotient ready");

endmodule
